@@ rtl/watch_slot_pool_allocator_unit_macros.svh @@
// Assertion macros for the watch slot pool allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WATCH_SLOT_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define WATCH_SLOT_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define WSPA_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define WSPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wspa_pkg.sv @@
// Shared constants, codes and store command types for the watch slot pool allocator.
// No dependencies.
package wspa_pkg;

   localparam int SLOTS       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int LINK_W      = IDX_W + 1;
   localparam int CNT_MAX     = (SLOTS > MAX_RESULTS) ? SLOTS : MAX_RESULTS;
   localparam int CNT_W       = $clog2(CNT_MAX + 1);

   localparam int KIND_W = 2;
   localparam int NUM_W  = 5;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]  rd_addr;
      logic              link_we;
      logic [IDX_W-1:0]  link_waddr;
      logic [LINK_W-1:0] link_wdata;
      logic              val_we;
      logic [IDX_W-1:0]  val_waddr;
      logic [VAL_W-1:0]  val_wdata;
   } store_cmd_type;

   typedef struct packed {
      logic [LINK_W-1:0] link;
      logic [VAL_W-1:0]  value;
   } store_data_type;

endpackage

@@ rtl/wspa_channels.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on wspa_pkg for field widths.
interface wspa_req_if;
   logic                       valid;
   logic                       ready;
   logic [wspa_pkg::KIND_W-1:0] kind;
   logic [wspa_pkg::VAL_W-1:0]  watch_value;
   logic [wspa_pkg::NUM_W-1:0]  slot_number;

   modport source (output valid, kind, watch_value, slot_number, input ready);
   modport sink   (input valid, kind, watch_value, slot_number, output ready);
endinterface

interface wspa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wspa_pkg::STAT_W-1:0] status;
   logic [wspa_pkg::NUM_W-1:0]  entry_number;
   logic [wspa_pkg::VAL_W-1:0]  entry_value;
   logic                        last;

   modport source (output valid, status, entry_number, entry_value, last, input ready);
   modport sink   (input valid, status, entry_number, entry_value, last, output ready);
endinterface

@@ rtl/watch_slot_pool_allocator_unit.sv @@
// Channel   | Dir | Fields                                          | Beat when
// req_chan  | in  | kind, watch_value, slot_number                  | valid & ready
// rsp_chan  | out | status, entry_number, entry_value, last         | valid & ready
//
// One item at a time; req_chan.ready is high only while idle.
// Allocate: S_ALLOC_POP takes the free head, S_ALLOC_LINK appends it to a non-empty
// active list, then the result beat. Free: S_FREE_WALK walks up to 32 active slots,
// then S_FREE_PUSH on a hit (a miss skips it). List: S_LIST_EMIT, a beat per slot.
// Empty or exhausted cases go straight to the result beat; kind 3 is dropped.
// A result beat waits in the output register for rsp_chan.ready; the walk stalls there.
// Reset is synchronous; the pool is usable right after it.
// Depends on wspa_pkg, wspa_channels, wspa_store and the macro header.
`include "watch_slot_pool_allocator_unit_macros.svh"

module watch_slot_pool_allocator_unit (
   input logic       clock,
   input logic       reset,
   wspa_req_if.sink  req_chan,
   wspa_rsp_if.source rsp_chan
);

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_ALLOC_POP  = 7'b0000010,
      S_ALLOC_LINK = 7'b0000100,
      S_FREE_WALK  = 7'b0001000,
      S_FREE_PUSH  = 7'b0010000,
      S_LIST_EMIT  = 7'b0100000,
      S_RESP       = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [wspa_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [wspa_pkg::VAL_W-1:0]    value_ff, value_in;
   logic [wspa_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [wspa_pkg::LINK_W-1:0]   cur_ff, cur_in;
   logic [wspa_pkg::LINK_W-1:0]   prev_ff, prev_in;
   logic [wspa_pkg::CNT_W-1:0]    step_ff, step_in;
   logic [wspa_pkg::LINK_W-1:0]   free_head_ff, free_head_in;
   logic [wspa_pkg::LINK_W-1:0]   act_head_ff, act_head_in;
   logic [wspa_pkg::LINK_W-1:0]   act_tail_ff, act_tail_in;
   logic [wspa_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [wspa_pkg::NUM_W-1:0]    entry_num_ff, entry_num_in;
   logic [wspa_pkg::VAL_W-1:0]    entry_val_ff, entry_val_in;
   logic                          last_ff, last_in;

   wspa_pkg::store_cmd_type  cmd;
   wspa_pkg::store_data_type rdata;

   logic                          req_beat;
   logic                          rsp_beat;
   logic [wspa_pkg::CNT_W-1:0]    step_nx;
   logic                          cur_match;

   wspa_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rdata (rdata)
   );

   assign req_beat  = req_chan.valid && req_chan.ready;
   assign rsp_beat  = rsp_chan.valid && rsp_chan.ready;
   assign step_nx   = step_ff + wspa_pkg::CNT_W'(1);
   assign cur_match = (cur_ff == wspa_pkg::LINK_W'(num_ff));

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = (state_ff == S_RESP);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.entry_number = entry_num_ff;
   assign rsp_chan.entry_value  = entry_val_ff;
   assign rsp_chan.last         = last_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      num_in       = num_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      free_head_in = free_head_ff;
      act_head_in  = act_head_ff;
      act_tail_in  = act_tail_ff;
      status_in    = status_ff;
      entry_num_in = entry_num_ff;
      entry_val_in = entry_val_ff;
      last_in      = last_ff;

      cmd            = '0;
      cmd.rd_addr    = cur_ff[wspa_pkg::IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            // read is issued in the accept cycle so data is ready next cycle
            cmd.rd_addr = (req_chan.kind == wspa_pkg::KIND_ALLOC)
                          ? free_head_ff[wspa_pkg::IDX_W-1:0]
                          : act_head_ff[wspa_pkg::IDX_W-1:0];
            if (req_beat) begin
               kind_in      = req_chan.kind;
               value_in     = req_chan.watch_value;
               num_in       = req_chan.slot_number;
               prev_in      = wspa_pkg::NULL_LINK;
               step_in      = '0;
               entry_val_in = '0;
               last_in      = 1'b1;
               if (req_chan.kind == wspa_pkg::KIND_ALLOC) begin
                  cur_in = free_head_ff;
                  if (free_head_ff == wspa_pkg::NULL_LINK) begin
                     status_in    = wspa_pkg::ST_EXHAUSTED;
                     entry_num_in = '0;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_ALLOC_POP;
                  end
               end else if (req_chan.kind == wspa_pkg::KIND_FREE) begin
                  cur_in = act_head_ff;
                  if (act_head_ff == wspa_pkg::NULL_LINK) begin
                     status_in    = wspa_pkg::ST_EMPTY;
                     entry_num_in = req_chan.slot_number;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_FREE_WALK;
                  end
               end else if (req_chan.kind == wspa_pkg::KIND_LIST) begin
                  cur_in = act_head_ff;
                  if (act_head_ff == wspa_pkg::NULL_LINK) begin
                     status_in    = wspa_pkg::ST_EMPTY;
                     entry_num_in = '0;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_LIST_EMIT;
                  end
               end
            end
         end

         S_ALLOC_POP: begin
            free_head_in   = rdata.link;
            cmd.link_we    = 1'b1;
            cmd.link_waddr = cur_ff[wspa_pkg::IDX_W-1:0];
            cmd.link_wdata = wspa_pkg::NULL_LINK;
            cmd.val_we     = 1'b1;
            cmd.val_waddr  = cur_ff[wspa_pkg::IDX_W-1:0];
            cmd.val_wdata  = value_ff;
            status_in      = wspa_pkg::ST_OK;
            entry_num_in   = wspa_pkg::NUM_W'(cur_ff);
            entry_val_in   = value_ff;
            last_in        = 1'b1;
            if (act_head_ff == wspa_pkg::NULL_LINK || act_tail_ff == wspa_pkg::NULL_LINK) begin
               act_head_in = cur_ff;
               act_tail_in = cur_ff;
               state_in    = S_RESP;
            end else begin
               state_in = S_ALLOC_LINK;
            end
         end

         S_ALLOC_LINK: begin
            cmd.link_we    = 1'b1;
            cmd.link_waddr = act_tail_ff[wspa_pkg::IDX_W-1:0];
            cmd.link_wdata = cur_ff;
            act_tail_in    = cur_ff;
            state_in       = S_RESP;
         end

         S_FREE_WALK: begin
            // rdata.link is the successor of cur; fetch its link for the next step
            cmd.rd_addr = rdata.link[wspa_pkg::IDX_W-1:0];
            if (cur_match) begin
               if (prev_ff == wspa_pkg::NULL_LINK) begin
                  act_head_in = rdata.link;
               end else begin
                  cmd.link_we    = 1'b1;
                  cmd.link_waddr = prev_ff[wspa_pkg::IDX_W-1:0];
                  cmd.link_wdata = rdata.link;
               end
               if (act_tail_ff == cur_ff) begin
                  act_tail_in = prev_ff;
               end
               cmd.val_we    = 1'b1;
               cmd.val_waddr = cur_ff[wspa_pkg::IDX_W-1:0];
               cmd.val_wdata = '0;
               status_in     = wspa_pkg::ST_OK;
               entry_num_in  = wspa_pkg::NUM_W'(cur_ff);
               state_in      = S_FREE_PUSH;
            end else begin
               prev_in = cur_ff;
               cur_in  = rdata.link;
               step_in = step_nx;
               if (rdata.link == wspa_pkg::NULL_LINK
                   || step_nx == wspa_pkg::CNT_W'(wspa_pkg::SLOTS)) begin
                  status_in    = wspa_pkg::ST_NOT_ACTIVE;
                  entry_num_in = num_ff;
                  state_in     = S_RESP;
               end
            end
         end

         S_FREE_PUSH: begin
            cmd.link_we    = 1'b1;
            cmd.link_waddr = cur_ff[wspa_pkg::IDX_W-1:0];
            cmd.link_wdata = free_head_ff;
            free_head_in   = cur_ff;
            state_in       = S_RESP;
         end

         S_LIST_EMIT: begin
            status_in    = wspa_pkg::ST_OK;
            entry_num_in = wspa_pkg::NUM_W'(cur_ff);
            entry_val_in = rdata.value;
            last_in      = (rdata.link == wspa_pkg::NULL_LINK)
                           || (step_nx == wspa_pkg::CNT_W'(wspa_pkg::MAX_RESULTS));
            cur_in       = rdata.link;
            step_in      = step_nx;
            state_in     = S_RESP;
         end

         S_RESP: begin
            // cur already holds the next slot of a listing; its read runs here
            if (rsp_beat) begin
               if (kind_ff == wspa_pkg::KIND_LIST && !last_ff) begin
                  state_in = S_LIST_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         act_head_ff  <= wspa_pkg::NULL_LINK;
         act_tail_ff  <= wspa_pkg::NULL_LINK;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         act_head_ff  <= act_head_in;
         act_tail_ff  <= act_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      num_ff       <= num_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      step_ff      <= step_in;
      status_ff    <= status_in;
      entry_num_ff <= entry_num_in;
      entry_val_ff <= entry_val_in;
      last_ff      <= last_in;
   end

   `WSPA_ASSERT_IMPL(a_no_accept_while_rsp, clock, reset,
      rsp_chan.valid, !req_chan.ready,
      "request accepted while a result beat is pending")
   `WSPA_ASSERT_NEXT(a_unused_kind_dropped, clock, reset,
      req_beat && req_chan.kind == wspa_pkg::KIND_UNUSED,
      req_chan.ready && !rsp_chan.valid,
      "unused kind did not return to idle silently")
   `WSPA_ASSERT_IMPL(a_only_list_not_last, clock, reset,
      rsp_chan.valid && !rsp_chan.last,
      rsp_chan.status == wspa_pkg::ST_OK && kind_ff == wspa_pkg::KIND_LIST,
      "non-final beat outside a good listing")
   `WSPA_ASSERT_ALWAYS(a_head_tail_null, clock, reset,
      (act_head_ff == wspa_pkg::NULL_LINK) == (act_tail_ff == wspa_pkg::NULL_LINK),
      "active head and tail disagree on empty")
   `WSPA_ASSERT_IMPL(a_exhausted_real, clock, reset,
      rsp_chan.valid && rsp_chan.status == wspa_pkg::ST_EXHAUSTED,
      free_head_ff == wspa_pkg::NULL_LINK,
      "exhausted reported with free slots left")

endmodule

@@ rtl/wspa_store.sv @@
// Link and value memories of the slot pool, one registered read port shared by both.
// Per-entry valid bits give the reset contents until an entry is first written.
// Depends on wspa_pkg.
module wspa_store (
   input  logic                     clock,
   input  logic                     reset,
   input  wspa_pkg::store_cmd_type  cmd,
   output wspa_pkg::store_data_type rdata
);

   logic [wspa_pkg::LINK_W-1:0] link_mem [wspa_pkg::SLOTS];
   logic [wspa_pkg::VAL_W-1:0]  val_mem  [wspa_pkg::SLOTS];

   logic [wspa_pkg::SLOTS-1:0]  link_vld_ff, link_vld_in;
   logic [wspa_pkg::SLOTS-1:0]  val_vld_ff, val_vld_in;

   logic [wspa_pkg::LINK_W-1:0] link_q_ff;
   logic [wspa_pkg::VAL_W-1:0]  val_q_ff;
   logic                        link_vq_ff;
   logic                        val_vq_ff;
   logic [wspa_pkg::IDX_W-1:0]  addr_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.link_we) begin
         link_mem[cmd.link_waddr] <= cmd.link_wdata;
      end
      if (cmd.val_we) begin
         val_mem[cmd.val_waddr] <= cmd.val_wdata;
      end
      link_q_ff  <= link_mem[cmd.rd_addr];
      val_q_ff   <= val_mem[cmd.rd_addr];
      link_vq_ff <= link_vld_ff[cmd.rd_addr];
      val_vq_ff  <= val_vld_ff[cmd.rd_addr];
      addr_q_ff  <= cmd.rd_addr;
   end

   always_comb begin
      link_vld_in = link_vld_ff;
      val_vld_in  = val_vld_ff;
      if (cmd.link_we) begin
         link_vld_in[cmd.link_waddr] = 1'b1;
      end
      if (cmd.val_we) begin
         val_vld_in[cmd.val_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
         val_vld_ff  <= '0;
      end else begin
         link_vld_ff <= link_vld_in;
         val_vld_ff  <= val_vld_in;
      end
   end

   // untouched entries: slot i links to i+1 (last one to null), value zero
   assign rdata.link  = link_vq_ff ? link_q_ff
                                   : wspa_pkg::LINK_W'(addr_q_ff) + wspa_pkg::LINK_W'(1);
   assign rdata.value = val_vq_ff ? val_q_ff : '0;

endmodule

@@ tb/wspa_pool_checker.sv @@
// Checker for the watch slot pool allocator: watches the request and response channels,
// keeps a shadow copy of the free and active slot lists, compares every response beat.
// Depends on wspa_pkg and the channel interfaces in wspa_channels.
module wspa_pool_checker (
   input  logic clock,
   input  logic reset,
   wspa_req_if  req_mon,
   wspa_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [wspa_pkg::STAT_W-1:0] status;
      logic [wspa_pkg::NUM_W-1:0]  number;
      logic [wspa_pkg::VAL_W-1:0]  value;
      logic                        last;
   } slot_result_type;

   // shadow pool: link of each slot, stored values, list heads
   logic [wspa_pkg::LINK_W-1:0] next_slot [wspa_pkg::SLOTS];
   logic [wspa_pkg::VAL_W-1:0]  held_value [wspa_pkg::SLOTS];
   logic [wspa_pkg::LINK_W-1:0] active_first;
   logic [wspa_pkg::LINK_W-1:0] active_last;
   logic [wspa_pkg::LINK_W-1:0] free_top;

   slot_result_type expected_results[$];

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic expect_beat(input logic [wspa_pkg::STAT_W-1:0] st,
                              input logic [wspa_pkg::NUM_W-1:0] num,
                              input logic [wspa_pkg::VAL_W-1:0] val, input logic fin);
      slot_result_type r;
      r.status = st;
      r.number = num;
      r.value  = val;
      r.last   = fin;
      expected_results.push_back(r);
   endtask

   task automatic clear_pool();
      for (int i = 0; i < wspa_pkg::SLOTS; i++) begin
         next_slot[i]  = wspa_pkg::LINK_W'(i + 1);
         held_value[i] = '0;
      end
      active_first = wspa_pkg::NULL_LINK;
      active_last  = wspa_pkg::NULL_LINK;
      free_top     = '0;
      expected_results.delete();
   endtask

   task automatic allocate_slot(input logic [wspa_pkg::VAL_W-1:0] val);
      logic [wspa_pkg::IDX_W-1:0] s;
      if (free_top >= wspa_pkg::SLOTS) begin
         expect_beat(wspa_pkg::ST_EXHAUSTED, '0, '0, 1'b1);
         return;
      end
      s = free_top[wspa_pkg::IDX_W-1:0];
      free_top      = next_slot[s];
      next_slot[s]  = wspa_pkg::NULL_LINK;
      held_value[s] = val;
      if (active_first >= wspa_pkg::SLOTS || active_last >= wspa_pkg::SLOTS)
         active_first = {1'b0, s};
      else
         next_slot[active_last[wspa_pkg::IDX_W-1:0]] = {1'b0, s};
      active_last = {1'b0, s};
      expect_beat(wspa_pkg::ST_OK, s, val, 1'b1);
   endtask

   task automatic release_slot(input logic [wspa_pkg::NUM_W-1:0] num);
      logic [wspa_pkg::LINK_W-1:0] prev;
      logic [wspa_pkg::LINK_W-1:0] cur;
      logic [wspa_pkg::LINK_W-1:0] nxt;
      int steps;
      if (active_first >= wspa_pkg::SLOTS) begin
         expect_beat(wspa_pkg::ST_EMPTY, num, '0, 1'b1);
         return;
      end
      prev  = wspa_pkg::NULL_LINK;
      cur   = active_first;
      steps = 0;
      while (cur < wspa_pkg::SLOTS && steps < wspa_pkg::SLOTS) begin
         if (cur == {1'b0, num}) begin
            nxt = next_slot[num];
            if (prev >= wspa_pkg::SLOTS)
               active_first = nxt;
            else
               next_slot[prev[wspa_pkg::IDX_W-1:0]] = nxt;
            if (active_last == cur)
               active_last = prev;
            held_value[num] = '0;
            next_slot[num]  = free_top;
            free_top        = cur;
            expect_beat(wspa_pkg::ST_OK, num, '0, 1'b1);
            return;
         end
         prev = cur;
         cur  = next_slot[cur[wspa_pkg::IDX_W-1:0]];
         steps++;
      end
      expect_beat(wspa_pkg::ST_NOT_ACTIVE, num, '0, 1'b1);
   endtask

   task automatic list_active_slots();
      logic [wspa_pkg::LINK_W-1:0] cur;
      logic [wspa_pkg::LINK_W-1:0] nxt;
      int k;
      cur = active_first;
      k   = 0;
      if (cur >= wspa_pkg::SLOTS) begin
         expect_beat(wspa_pkg::ST_EMPTY, '0, '0, 1'b1);
         return;
      end
      while (cur < wspa_pkg::SLOTS && k < wspa_pkg::MAX_RESULTS) begin
         nxt = next_slot[cur[wspa_pkg::IDX_W-1:0]];
         expect_beat(wspa_pkg::ST_OK, cur[wspa_pkg::IDX_W-1:0],
                     held_value[cur[wspa_pkg::IDX_W-1:0]],
                     (nxt >= wspa_pkg::SLOTS) || (k + 1 == wspa_pkg::MAX_RESULTS));
         k++;
         cur = nxt;
      end
   endtask

   always @(posedge clock) begin
      slot_result_type got;
      slot_result_type want;
      if (reset) begin
         clear_pool();
         fail_count = 0;
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.kind)
               wspa_pkg::KIND_ALLOC: allocate_slot(req_mon.watch_value);
               wspa_pkg::KIND_FREE:  release_slot(req_mon.slot_number);
               wspa_pkg::KIND_LIST:  list_active_slots();
               default: ;  // unused kind is dropped without a beat
            endcase
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.status = rsp_mon.status;
            got.number = rsp_mon.entry_number;
            got.value  = rsp_mon.entry_value;
            got.last   = rsp_mon.last;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected beat status %0d entry %0d value %h last %0d",
                                         got.status, got.number, got.value, got.last));
            end else begin
               want = expected_results.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "got/exp status %0d/%0d entry %0d/%0d value %h/%h last %0d/%0d",
                     got.status, want.status, got.number, want.number,
                     got.value, want.value, got.last, want.last));
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

@@ tb/tb_watch_slot_pool_allocator_unit.sv @@
// Testbench top for watch_slot_pool_allocator_unit: clock, reset, request stimulus with
// bursts and gaps, response back-pressure, and the verdict from wspa_pool_checker.
// Depends on wspa_pkg, wspa_channels, the RTL and wspa_pool_checker.
module tb_watch_slot_pool_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_START    = 200;
   localparam int HOLD_LEN      = 300;
   localparam int SETTLE_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_results;
   int   cycle_count = 0;
   int   burst_left = 0;

   wspa_req_if req_if ();
   wspa_rsp_if rsp_if ();

   watch_slot_pool_allocator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   wspa_pool_checker pool_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL watch_slot_pool_allocator_unit");
         $finish;
      end
   end

   // Offer one beat; between bursts valid drops for a random gap.
   task automatic offer(input logic [wspa_pkg::KIND_W-1:0] k,
                        input logic [wspa_pkg::VAL_W-1:0] v,
                        input logic [wspa_pkg::NUM_W-1:0] n);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid       = 1'b1;
      req_if.kind        = k;
      req_if.watch_value = v;
      req_if.slot_number = n;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // Weighted random beats; dropped kinds do not count.
   task automatic random_mix(input int count, input int alloc_pct, input int free_pct,
                             input int list_pct);
      int done;
      int roll;
      logic [wspa_pkg::KIND_W-1:0] k;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct)
            k = wspa_pkg::KIND_ALLOC;
         else if (roll < alloc_pct + free_pct)
            k = wspa_pkg::KIND_FREE;
         else if (roll < alloc_pct + free_pct + list_pct)
            k = wspa_pkg::KIND_LIST;
         else
            k = wspa_pkg::KIND_UNUSED;
         offer(k, $urandom(), wspa_pkg::NUM_W'($urandom_range(0, wspa_pkg::SLOTS - 1)));
         if (k != wspa_pkg::KIND_UNUSED)
            done++;
      end
   endtask

   // Response side: mixed stall patterns, plus one long hold-off.
   initial begin
      int span;
      int mode;
      int rcv_cycles;
      bit held;
      rcv_cycles = 0;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 40);
         repeat (span) begin
            @(negedge clock);
            rcv_cycles++;
            if (!held && rcv_cycles >= HOLD_START) begin
               held = 1'b1;
               rsp_if.ready = 1'b0;
               repeat (HOLD_LEN - 1) @(negedge clock);
            end else begin
               case (mode)
                  0: rsp_if.ready = 1'b1;
                  1: rsp_if.ready = ($urandom_range(0, 99) < 60);
                  default: rsp_if.ready = ((rcv_cycles / 5) % 2 == 0);
               endcase
            end
         end
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.kind        = wspa_pkg::KIND_ALLOC;
      req_if.watch_value = '0;
      req_if.slot_number = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pool cases and a dropped kind
      offer(wspa_pkg::KIND_LIST, 32'h0, 5'd0);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd0);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd31);
      offer(wspa_pkg::KIND_UNUSED, 32'h0, 5'd0);
      // fill slots 0..3 with extreme and patterned values
      offer(wspa_pkg::KIND_ALLOC, 32'h0000_0000, 5'd0);
      offer(wspa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 5'd31);
      offer(wspa_pkg::KIND_ALLOC, 32'hA5A5_A5A5, 5'd0);
      offer(wspa_pkg::KIND_ALLOC, 32'h5A5A_5A5A, 5'd0);
      offer(wspa_pkg::KIND_LIST, $urandom(), 5'd0);
      // not active, middle, head, tail, then the freed tail again (not active)
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd31);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd1);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd0);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd3);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd3);
      offer(wspa_pkg::KIND_LIST, $urandom(), 5'd31);
      // LIFO reuse of the last freed slot
      offer(wspa_pkg::KIND_ALLOC, 32'h1234_5678, 5'd0);
      offer(wspa_pkg::KIND_UNUSED, 32'hFFFF_FFFF, 5'd31);
      offer(wspa_pkg::KIND_LIST, $urandom(), 5'd0);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd2);
      offer(wspa_pkg::KIND_FREE, $urandom(), 5'd3);
      offer(wspa_pkg::KIND_LIST, $urandom(), 5'd0);

      // fill toward exhaustion, then drain, then a balanced mix
      random_mix(45, 85, 7, 6);
      random_mix(25, 20, 65, 13);
      random_mix(19, 45, 40, 12);

      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("PASS watch_slot_pool_allocator_unit");
      else
         $display("FAIL watch_slot_pool_allocator_unit");
      $finish;
   end

endmodule
